FILE: rtl/det_pkg.sv
package det_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int COST_W     = 19;
    localparam int SLOT_W     = 4;
    localparam int RAND_W     = 16;
    localparam int RATE_W     = 17;
    localparam int SCALE_W    = 18;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    // Multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MUTP_W  = DIFF_W + MUL_B_W;
    localparam int CUBE_W  = 3 * COORD_W - 1;
    localparam int SUM_W   = CUBE_W + 1;
    localparam int WORD_W  = 2 * COORD_W + COST_W;

    // Population size default and cost limits
    localparam int POP_SIZE_DEF = 16;
    localparam int COST_MAX     = 221184;

    // Register reset values
    localparam int RATE_RESET     = 58982;
    localparam int SCALE_RESET    = 32768;
    localparam int BOUND_LO_RESET = -12288;
    localparam int BOUND_HI_RESET = 12288;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_Y = 3'd5;

    // Operation codes of the request
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_TRIAL = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED   = 2'd0,
        ST_REPLACED = 2'd1,
        ST_KEPT     = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_TGT,
        RD_BASE,
        RD_PLUS,
        RD_MINUS
    } rd_sel_t;

    typedef enum logic [2:0] {
        LOP_NONE,
        LOP_LOAD,
        LOP_MUT,
        LOP_CLAMP,
        LOP_SQR,
        LOP_CUB
    } lane_op_t;

    typedef struct packed {
        logic     cap_own;
        logic     cap_base;
        logic     cap_plus;
        logic     cap_minus;
        lane_op_t op;
    } lane_cmd_t;

    typedef struct packed {
        logic     cap_item;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     cap_own;
        logic     cap_base;
        logic     cap_plus;
        logic     cap_minus;
        lane_op_t lane_op;
        logic     cost_en;
        logic     decide;
        logic     reject;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_load;
        logic idx_ok;
    } dp_stat_t;

endpackage

FILE: rtl/det_ram.sv
module det_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/det_lane.sv
module det_lane (
    input  logic                                aclk,
    input  det_pkg::lane_cmd_t                  cmd,
    input  logic                                take_mut,
    input  logic [det_pkg::SCALE_W-1:0]         scale,
    input  logic signed [det_pkg::COORD_W-1:0]  lower,
    input  logic signed [det_pkg::COORD_W-1:0]  upper,
    input  logic signed [det_pkg::COORD_W-1:0]  load_val,
    input  logic signed [det_pkg::COORD_W-1:0]  rd_coord,
    output logic signed [det_pkg::COORD_W-1:0]  val,
    output logic signed [det_pkg::CUBE_W-1:0]   cube
);

    localparam int VW = det_pkg::COORD_W + 5;
    localparam int MW = det_pkg::MUTP_W - 16;

    logic signed [det_pkg::COORD_W-1:0] own_reg;
    logic signed [det_pkg::COORD_W-1:0] base_reg;
    logic signed [det_pkg::COORD_W-1:0] plus_reg;
    logic signed [det_pkg::COORD_W-1:0] minus_reg;
    logic signed [det_pkg::COORD_W-1:0] val_reg;
    logic signed [det_pkg::COORD_W-1:0] val_next;
    logic signed [det_pkg::PROD_W-1:0]  prod_reg;
    logic signed [det_pkg::PROD_W-1:0]  prod_next;

    logic signed [det_pkg::DIFF_W-1:0]  diff;
    logic signed [det_pkg::MUL_A_W-1:0] mul_a;
    logic signed [det_pkg::MUL_B_W-1:0] mul_b;
    logic signed [det_pkg::MUTP_W-1:0]  mut_rnd;
    logic signed [MW-1:0]               mut_step;
    logic signed [VW-1:0]               mut_sum;
    logic signed [VW-1:0]               pick;

    // Difference of the two operand points.
    assign diff = det_pkg::DIFF_W'(plus_reg) - det_pkg::DIFF_W'(minus_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.op)
            det_pkg::LOP_MUT: begin
                mul_a = det_pkg::MUL_A_W'(diff);
                mul_b = $signed({1'b0, scale});
            end
            det_pkg::LOP_SQR: begin
                mul_a = det_pkg::MUL_A_W'(val_reg);
                mul_b = det_pkg::MUL_B_W'(val_reg);
            end
            det_pkg::LOP_CUB: begin
                mul_a = prod_reg[det_pkg::MUL_A_W-1:0];
                mul_b = det_pkg::MUL_B_W'(val_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Round the scaled difference half up, add the base, pick it or the own value, then clamp.
    assign mut_rnd  = prod_reg[det_pkg::MUTP_W-1:0] + det_pkg::MUTP_W'(32768);
    assign mut_step = mut_rnd[det_pkg::MUTP_W-1:16];
    assign mut_sum  = VW'(base_reg) + VW'(mut_step);
    assign pick     = take_mut ? mut_sum : VW'(own_reg);

    always_comb begin
        priority if (pick > VW'(upper)) begin
            val_next = upper;
        end else if (pick < VW'(lower)) begin
            val_next = lower;
        end else begin
            val_next = pick[det_pkg::COORD_W-1:0];
        end
    end

    // Operand capture and the per-step result registers.
    always_ff @(posedge aclk) begin
        if (cmd.cap_own) begin
            own_reg <= rd_coord;
        end
        if (cmd.cap_base) begin
            base_reg <= rd_coord;
        end
        if (cmd.cap_plus) begin
            plus_reg <= rd_coord;
        end
        if (cmd.cap_minus) begin
            minus_reg <= rd_coord;
        end
        unique case (cmd.op)
            det_pkg::LOP_LOAD: begin
                val_reg <= load_val;
            end
            det_pkg::LOP_CLAMP: begin
                val_reg <= val_next;
            end
            det_pkg::LOP_MUT, det_pkg::LOP_SQR, det_pkg::LOP_CUB: begin
                prod_reg <= prod_next;
            end
            default: begin
            end
        endcase
    end

    assign val  = val_reg;
    assign cube = prod_reg[det_pkg::CUBE_W-1:0];

endmodule

FILE: rtl/det_datapath.sv
module det_datapath #(
    parameter int POP_SIZE = det_pkg::POP_SIZE_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [det_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [det_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  det_pkg::dp_cmd_t                      cmd,
    output det_pkg::dp_stat_t                     stat,
    input  logic                                  in_func,
    input  logic [det_pkg::SLOT_W-1:0]            in_slot,
    input  logic [det_pkg::SLOT_W-1:0]            in_base_slot,
    input  logic [det_pkg::SLOT_W-1:0]            in_plus_slot,
    input  logic [det_pkg::SLOT_W-1:0]            in_minus_slot,
    input  logic [det_pkg::RAND_W-1:0]            in_rand_x,
    input  logic [det_pkg::RAND_W-1:0]            in_rand_y,
    input  logic signed [det_pkg::COORD_W-1:0]    in_load_x,
    input  logic signed [det_pkg::COORD_W-1:0]    in_load_y,
    output det_pkg::status_t                      res_status,
    output logic signed [det_pkg::COST_W-1:0]     res_point_cost,
    output logic signed [det_pkg::COORD_W-1:0]    res_point_x,
    output logic signed [det_pkg::COORD_W-1:0]    res_point_y,
    output logic [det_pkg::SLOT_W-1:0]            res_best_slot,
    output logic signed [det_pkg::COST_W-1:0]     res_best_cost
);

    localparam int AW  = $clog2(POP_SIZE);
    localparam int CSW = det_pkg::SUM_W - 24;

    // Configuration registers
    logic [det_pkg::RATE_W-1:0]         rate_reg;
    logic [det_pkg::SCALE_W-1:0]        scale_reg;
    logic signed [det_pkg::COORD_W-1:0] lower_x_reg;
    logic signed [det_pkg::COORD_W-1:0] upper_x_reg;
    logic signed [det_pkg::COORD_W-1:0] lower_y_reg;
    logic signed [det_pkg::COORD_W-1:0] upper_y_reg;

    // Request registers
    logic                               func_reg;
    logic [det_pkg::SLOT_W-1:0]         slot_reg;
    logic [det_pkg::SLOT_W-1:0]         base_slot_reg;
    logic [det_pkg::SLOT_W-1:0]         plus_slot_reg;
    logic [det_pkg::SLOT_W-1:0]         minus_slot_reg;
    logic [det_pkg::RAND_W-1:0]         rand_x_reg;
    logic [det_pkg::RAND_W-1:0]         rand_y_reg;
    logic signed [det_pkg::COORD_W-1:0] load_x_reg;
    logic signed [det_pkg::COORD_W-1:0] load_y_reg;

    // Working and result registers
    logic signed [det_pkg::COST_W-1:0]  own_cost_reg;
    logic signed [det_pkg::COST_W-1:0]  cost_reg;
    logic signed [det_pkg::COST_W-1:0]  cost_next;
    det_pkg::status_t                   status_reg;
    logic [det_pkg::SLOT_W-1:0]         best_slot_reg;
    logic signed [det_pkg::COST_W-1:0]  best_cost_reg;
    det_pkg::status_t                   out_status_reg;
    logic signed [det_pkg::COST_W-1:0]  out_cost_reg;
    logic signed [det_pkg::COORD_W-1:0] out_x_reg;
    logic signed [det_pkg::COORD_W-1:0] out_y_reg;
    logic [det_pkg::SLOT_W-1:0]         out_best_slot_reg;
    logic signed [det_pkg::COST_W-1:0]  out_best_cost_reg;

    logic                               trial_ok;
    logic                               load_ok;
    logic                               replace;
    logic                               wr_en;
    logic [AW-1:0]                      rd_addr;
    logic [det_pkg::WORD_W-1:0]         wr_word;
    logic [det_pkg::WORD_W-1:0]         rd_word;
    det_pkg::lane_cmd_t                 lane_cmd;
    logic                               take_x;
    logic                               take_y;
    logic signed [det_pkg::COORD_W-1:0] val_x;
    logic signed [det_pkg::COORD_W-1:0] val_y;
    logic signed [det_pkg::CUBE_W-1:0]  cube_x;
    logic signed [det_pkg::CUBE_W-1:0]  cube_y;
    logic signed [det_pkg::SUM_W-1:0]   cost_sum;
    logic signed [CSW-1:0]              cost_shift;

    // Configuration write port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg    <= det_pkg::RATE_W'(det_pkg::RATE_RESET);
            scale_reg   <= det_pkg::SCALE_W'(det_pkg::SCALE_RESET);
            lower_x_reg <= det_pkg::COORD_W'(det_pkg::BOUND_LO_RESET);
            upper_x_reg <= det_pkg::COORD_W'(det_pkg::BOUND_HI_RESET);
            lower_y_reg <= det_pkg::COORD_W'(det_pkg::BOUND_LO_RESET);
            upper_y_reg <= det_pkg::COORD_W'(det_pkg::BOUND_HI_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                det_pkg::CFG_RATE:    rate_reg    <= cfg_wdata[det_pkg::RATE_W-1:0];
                det_pkg::CFG_SCALE:   scale_reg   <= cfg_wdata[det_pkg::SCALE_W-1:0];
                det_pkg::CFG_LOWER_X: lower_x_reg <= cfg_wdata[det_pkg::COORD_W-1:0];
                det_pkg::CFG_UPPER_X: upper_x_reg <= cfg_wdata[det_pkg::COORD_W-1:0];
                det_pkg::CFG_LOWER_Y: lower_y_reg <= cfg_wdata[det_pkg::COORD_W-1:0];
                det_pkg::CFG_UPPER_Y: upper_y_reg <= cfg_wdata[det_pkg::COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the accepted request.
    always_ff @(posedge aclk) begin
        if (cmd.cap_item) begin
            func_reg       <= in_func;
            slot_reg       <= in_slot;
            base_slot_reg  <= in_base_slot;
            plus_slot_reg  <= in_plus_slot;
            minus_slot_reg <= in_minus_slot;
            rand_x_reg     <= in_rand_x;
            rand_y_reg     <= in_rand_y;
            load_x_reg     <= in_load_x;
            load_y_reg     <= in_load_y;
        end
    end

    // Slot checks: load slot in range; trial slots in range and distinct.
    assign load_ok  = 32'(slot_reg) < POP_SIZE;
    assign trial_ok = load_ok
                   && (32'(base_slot_reg) < POP_SIZE)
                   && (32'(plus_slot_reg) < POP_SIZE)
                   && (32'(minus_slot_reg) < POP_SIZE)
                   && (slot_reg != base_slot_reg) && (slot_reg != plus_slot_reg)
                   && (slot_reg != minus_slot_reg) && (base_slot_reg != plus_slot_reg)
                   && (base_slot_reg != minus_slot_reg) && (plus_slot_reg != minus_slot_reg);

    assign stat.is_load = (func_reg == det_pkg::FUNC_LOAD);
    assign stat.idx_ok  = stat.is_load ? load_ok : trial_ok;

    // Population memory: one word per slot holding cost, y and x.
    always_comb begin
        unique case (cmd.rd_sel)
            det_pkg::RD_TGT:   rd_addr = AW'(slot_reg);
            det_pkg::RD_BASE:  rd_addr = AW'(base_slot_reg);
            det_pkg::RD_PLUS:  rd_addr = AW'(plus_slot_reg);
            det_pkg::RD_MINUS: rd_addr = AW'(minus_slot_reg);
            default:           rd_addr = AW'(slot_reg);
        endcase
    end

    assign replace = (cost_reg <= own_cost_reg);
    assign wr_en   = cmd.decide && (stat.is_load || replace);
    assign wr_word = {cost_reg, val_y, val_x};

    det_ram #(
        .WIDTH (det_pkg::WORD_W),
        .DEPTH (POP_SIZE)
    ) u_pop_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(slot_reg)),
        .wr_data (wr_word),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // Coordinate lanes.
    assign lane_cmd.cap_own   = cmd.cap_own;
    assign lane_cmd.cap_base  = cmd.cap_base;
    assign lane_cmd.cap_plus  = cmd.cap_plus;
    assign lane_cmd.cap_minus = cmd.cap_minus;
    assign lane_cmd.op        = cmd.lane_op;

    assign take_x = {1'b0, rand_x_reg} <= rate_reg;
    assign take_y = {1'b0, rand_y_reg} <= rate_reg;

    det_lane u_lane_x (
        .aclk     (aclk),
        .cmd      (lane_cmd),
        .take_mut (take_x),
        .scale    (scale_reg),
        .lower    (lower_x_reg),
        .upper    (upper_x_reg),
        .load_val (load_x_reg),
        .rd_coord (rd_word[det_pkg::COORD_W-1:0]),
        .val      (val_x),
        .cube     (cube_x)
    );

    det_lane u_lane_y (
        .aclk     (aclk),
        .cmd      (lane_cmd),
        .take_mut (take_y),
        .scale    (scale_reg),
        .lower    (lower_y_reg),
        .upper    (upper_y_reg),
        .load_val (load_y_reg),
        .rd_coord (rd_word[2*det_pkg::COORD_W-1:det_pkg::COORD_W]),
        .val      (val_y),
        .cube     (cube_y)
    );

    // Cost: sum of cubes, rounded half up to Q7.12, then saturated.
    assign cost_sum   = det_pkg::SUM_W'(cube_x) + det_pkg::SUM_W'(cube_y)
                      + det_pkg::SUM_W'(8388608);
    assign cost_shift = cost_sum[det_pkg::SUM_W-1:24];

    always_comb begin
        priority if (cost_shift > CSW'(det_pkg::COST_MAX)) begin
            cost_next = det_pkg::COST_W'(det_pkg::COST_MAX);
        end else if (cost_shift < CSW'(-det_pkg::COST_MAX)) begin
            cost_next = det_pkg::COST_W'(-det_pkg::COST_MAX);
        end else begin
            cost_next = cost_shift[det_pkg::COST_W-1:0];
        end
    end

    // Cost, decision and result payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.cap_own) begin
            own_cost_reg <= rd_word[det_pkg::WORD_W-1:2*det_pkg::COORD_W];
        end
        if (cmd.cost_en) begin
            cost_reg <= cost_next;
        end
        if (cmd.decide) begin
            priority if (stat.is_load) begin
                status_reg <= det_pkg::ST_LOADED;
            end else if (replace) begin
                status_reg <= det_pkg::ST_REPLACED;
            end else begin
                status_reg <= det_pkg::ST_KEPT;
            end
        end else if (cmd.reject) begin
            status_reg <= det_pkg::ST_REJECTED;
        end
        if (cmd.out_load) begin
            out_status_reg    <= status_reg;
            out_best_slot_reg <= best_slot_reg;
            out_best_cost_reg <= best_cost_reg;
            if (status_reg == det_pkg::ST_REJECTED) begin
                out_cost_reg <= '0;
                out_x_reg    <= '0;
                out_y_reg    <= '0;
            end else begin
                out_cost_reg <= cost_reg;
                out_x_reg    <= val_x;
                out_y_reg    <= val_y;
            end
        end
    end

    // Running minimum over every written cost; ties go to the latest write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_cost_reg <= det_pkg::COST_W'(det_pkg::COST_MAX);
            best_slot_reg <= '0;
        end else if (wr_en && (cost_reg <= best_cost_reg)) begin
            best_cost_reg <= cost_reg;
            best_slot_reg <= slot_reg;
        end
    end

    assign res_status     = out_status_reg;
    assign res_point_cost = out_cost_reg;
    assign res_point_x    = out_x_reg;
    assign res_point_y    = out_y_reg;
    assign res_best_slot  = out_best_slot_reg;
    assign res_best_cost  = out_best_cost_reg;

endmodule

FILE: rtl/det_ctrl.sv
module det_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  det_pkg::dp_stat_t stat,
    output det_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD_B,
        S_RD_P,
        S_RD_Q,
        S_CAP_Q,
        S_MUT,
        S_CLAMP,
        S_LOAD,
        S_SQR,
        S_CUB,
        S_COST,
        S_DECIDE,
        S_REJECT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;

    // Command decode and next state.
    always_comb begin
        cmd        = '0;
        cmd.rd_sel = det_pkg::RD_TGT;
        cmd.lane_op = det_pkg::LOP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap_item = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (!stat.idx_ok) begin
                    state_next = S_REJECT;
                end else if (stat.is_load) begin
                    state_next = S_LOAD;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = det_pkg::RD_TGT;
                    state_next = S_RD_B;
                end
            end
            S_RD_B: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = det_pkg::RD_BASE;
                cmd.cap_own = 1'b1;
                state_next  = S_RD_P;
            end
            S_RD_P: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = det_pkg::RD_PLUS;
                cmd.cap_base = 1'b1;
                state_next   = S_RD_Q;
            end
            S_RD_Q: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = det_pkg::RD_MINUS;
                cmd.cap_plus = 1'b1;
                state_next   = S_CAP_Q;
            end
            S_CAP_Q: begin
                cmd.cap_minus = 1'b1;
                state_next    = S_MUT;
            end
            S_MUT: begin
                cmd.lane_op = det_pkg::LOP_MUT;
                state_next  = S_CLAMP;
            end
            S_CLAMP: begin
                cmd.lane_op = det_pkg::LOP_CLAMP;
                state_next  = S_SQR;
            end
            S_LOAD: begin
                cmd.lane_op = det_pkg::LOP_LOAD;
                state_next  = S_SQR;
            end
            S_SQR: begin
                cmd.lane_op = det_pkg::LOP_SQR;
                state_next  = S_CUB;
            end
            S_CUB: begin
                cmd.lane_op = det_pkg::LOP_CUB;
                state_next  = S_COST;
            end
            S_COST: begin
                cmd.cost_en = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_FINISH;
            end
            S_REJECT: begin
                cmd.reject = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/differential_evolution_trial_step.sv
// Differential evolution trial engine (rand/1/bin) for two-dimensional Q4.12 points.
// A load request writes a point and its cost x^3 + y^3 into a slot; a trial request
// mutates, crosses over, clamps and costs a new point and replaces the target slot
// when the new cost is lower or equal. One result follows every request. A trial
// passes through more controller states than a load, and a rejected request fewer;
// the pace is set by the single read port of the population memory (four reads
// per trial) and by the multiplier in each coordinate lane, which runs the mutation,
// the square and the cube one after another. The result sits in an output register,
// so the next request is accepted while an earlier result waits to be taken.
// Configuration may only be written while no request is in flight.
module differential_evolution_trial_step #(
    parameter int POP_SIZE = det_pkg::POP_SIZE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [det_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [det_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slot, base_slot, plus_slot, minus_slot, rand_x, rand_y, load_x, load_y
    input  logic [det_pkg::IN_DATA_W-1:0]     s_tdata,
    // func
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // point_cost, point_x, point_y, best_slot, best_cost, zero fill
    output logic [det_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [det_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int PAD_W = det_pkg::OUT_DATA_W - 2 * det_pkg::COST_W
                         - 2 * det_pkg::COORD_W - det_pkg::SLOT_W;

    det_pkg::dp_cmd_t                   cmd;
    det_pkg::dp_stat_t                  stat;
    det_pkg::status_t                   res_status;
    logic signed [det_pkg::COST_W-1:0]  res_point_cost;
    logic signed [det_pkg::COORD_W-1:0] res_point_x;
    logic signed [det_pkg::COORD_W-1:0] res_point_y;
    logic [det_pkg::SLOT_W-1:0]         res_best_slot;
    logic signed [det_pkg::COST_W-1:0]  res_best_cost;

    det_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    det_datapath #(
        .POP_SIZE (POP_SIZE)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .stat           (stat),
        .in_func        (s_tuser),
        .in_slot        (s_tdata[3:0]),
        .in_base_slot   (s_tdata[7:4]),
        .in_plus_slot   (s_tdata[11:8]),
        .in_minus_slot  (s_tdata[15:12]),
        .in_rand_x      (s_tdata[31:16]),
        .in_rand_y      (s_tdata[47:32]),
        .in_load_x      (s_tdata[63:48]),
        .in_load_y      (s_tdata[79:64]),
        .res_status     (res_status),
        .res_point_cost (res_point_cost),
        .res_point_x    (res_point_x),
        .res_point_y    (res_point_y),
        .res_best_slot  (res_best_slot),
        .res_best_cost  (res_best_cost)
    );

    // Pack the result, first field in the lowest bits.
    assign m_tdata = {{PAD_W{1'b0}}, res_best_cost, res_best_slot,
                      res_point_y, res_point_x, res_point_cost};
    assign m_tuser = res_status;

endmodule

FILE: sim/differential_evolution_trial_step_tb.sv
`timescale 1ns / 1ps

module differential_evolution_trial_step_tb;

    // One request as the sender sees it, before packing onto the bus.
    typedef struct {
        logic        func;
        logic [3:0]  slot;
        logic [3:0]  base_slot;
        logic [3:0]  plus_slot;
        logic [3:0]  minus_slot;
        logic [15:0] rand_x;
        logic [15:0] rand_y;
        logic [15:0] load_x;
        logic [15:0] load_y;
    } request_t;

    // One result with the fields at the widths of the result bus.
    typedef struct {
        det_pkg::status_t status;
        logic [18:0]      point_cost;
        logic [15:0]      point_x;
        logic [15:0]      point_y;
        logic [3:0]       best_slot;
        logic [18:0]      best_cost;
    } outcome_t;

    localparam longint CUBE_ROUND = 64'sd8388608;
    localparam longint MUT_ROUND  = 64'sd32768;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [det_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [det_pkg::CFG_DATA_W-1:0]   cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [det_pkg::IN_DATA_W-1:0]    s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [det_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [det_pkg::STATUS_W-1:0]     m_tuser;

    // Shadow copy of the population and the running minimum.
    longint pop_x [det_pkg::POP_SIZE_DEF];
    longint pop_y [det_pkg::POP_SIZE_DEF];
    longint pop_cost [det_pkg::POP_SIZE_DEF];
    longint lowest_cost;
    longint lowest_slot;

    // Shadow copy of the configuration registers.
    longint rate_q;
    longint scale_q;
    longint lo_x;
    longint hi_x;
    longint lo_y;
    longint hi_y;

    outcome_t pending_outcomes[$];

    int  mismatches;
    int  settings_used;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  sender_steady;
    bit  recv_steady;
    int  seen_loaded;
    int  seen_replaced;
    int  seen_kept;
    int  seen_rejected;

    differential_evolution_trial_step #(
        .POP_SIZE(det_pkg::POP_SIZE_DEF)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Cost x^3 + y^3 rounded half up from Q36 cubes to Q12, then saturated.
    function automatic longint cube_cost(longint x, longint y);
        longint c;
        c = (x * x * x + y * y * y + CUBE_ROUND) >>> 24;
        if (c > det_pkg::COST_MAX) begin
            c = det_pkg::COST_MAX;
        end else if (c < -det_pkg::COST_MAX) begin
            c = -det_pkg::COST_MAX;
        end
        return c;
    endfunction

    function automatic longint mutant(longint base, longint plus, longint minus);
        return base + (((plus - minus) * scale_q + MUT_ROUND) >>> 16);
    endfunction

    // The upper test comes first, so it wins when the bounds are crossed.
    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Running minimum: ties move the best slot to the latest write.
    function automatic void note_written_cost(longint cost, longint slot);
        if (cost <= lowest_cost) begin
            lowest_cost = cost;
            lowest_slot = slot;
        end
    endfunction

    // Applies one request to the shadow population and returns its result.
    function automatic outcome_t apply_to_population(request_t r);
        outcome_t o;
        longint   vx;
        longint   vy;
        longint   px;
        longint   py;
        longint   pc;
        bit       distinct;
        o.status = det_pkg::ST_REJECTED;
        px = 0;
        py = 0;
        pc = 0;
        // Every 4-bit slot lies inside the population of sixteen.
        if (r.func == det_pkg::FUNC_LOAD) begin
            px = longint'($signed(r.load_x));
            py = longint'($signed(r.load_y));
            pc = cube_cost(px, py);
            pop_x[r.slot] = px;
            pop_y[r.slot] = py;
            pop_cost[r.slot] = pc;
            note_written_cost(pc, r.slot);
            o.status = det_pkg::ST_LOADED;
        end else begin
            distinct = r.slot != r.base_slot && r.slot != r.plus_slot &&
                       r.slot != r.minus_slot && r.base_slot != r.plus_slot &&
                       r.base_slot != r.minus_slot && r.plus_slot != r.minus_slot;
            if (distinct) begin
                vx = pop_x[r.slot];
                vy = pop_y[r.slot];
                if (r.rand_x <= rate_q) begin
                    vx = mutant(pop_x[r.base_slot], pop_x[r.plus_slot], pop_x[r.minus_slot]);
                end
                if (r.rand_y <= rate_q) begin
                    vy = mutant(pop_y[r.base_slot], pop_y[r.plus_slot], pop_y[r.minus_slot]);
                end
                px = clamp(vx, lo_x, hi_x);
                py = clamp(vy, lo_y, hi_y);
                pc = cube_cost(px, py);
                if (pc <= pop_cost[r.slot]) begin
                    pop_x[r.slot] = px;
                    pop_y[r.slot] = py;
                    pop_cost[r.slot] = pc;
                    note_written_cost(pc, r.slot);
                    o.status = det_pkg::ST_REPLACED;
                end else begin
                    o.status = det_pkg::ST_KEPT;
                end
            end
        end
        o.point_cost = 19'(pc);
        o.point_x = 16'(px);
        o.point_y = 16'(py);
        o.best_slot = 4'(lowest_slot);
        o.best_cost = 19'(lowest_cost);
        return o;
    endfunction

    // Crossover randoms: zero, the top, the current rate, one above it, or any value.
    function automatic logic [15:0] crossover_random();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(rate_q);
            3: return 16'(rate_q + 1);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic request_t make_load(logic [3:0] slot, logic [15:0] x, logic [15:0] y);
        request_t r;
        r.func = det_pkg::FUNC_LOAD;
        r.slot = slot;
        r.base_slot = 4'($urandom);
        r.plus_slot = 4'($urandom);
        r.minus_slot = 4'($urandom);
        r.rand_x = 16'($urandom);
        r.rand_y = 16'($urandom);
        r.load_x = x;
        r.load_y = y;
        return r;
    endfunction

    function automatic request_t make_trial(logic [3:0] t, logic [3:0] b, logic [3:0] p,
                                            logic [3:0] q, logic [15:0] rx, logic [15:0] ry);
        request_t r;
        r = make_load(t, 16'($urandom), 16'($urandom));
        r.func = det_pkg::FUNC_TRIAL;
        r.base_slot = b;
        r.plus_slot = p;
        r.minus_slot = q;
        r.rand_x = rx;
        r.rand_y = ry;
        return r;
    endfunction

    // Mostly well-formed trials, some loads, and a tenth with repeated indices.
    function automatic request_t random_request();
        logic [3:0] order [16];
        logic [3:0] swap;
        int         kind;
        int         j;
        int         a;
        int         b;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            return make_load(4'($urandom), random_coord(), random_coord());
        end
        for (int i = 0; i < 16; i++) begin
            order[i] = 4'(i);
        end
        for (int k = 0; k < 4; k++) begin
            j = $urandom_range(k, 15);
            swap = order[k];
            order[k] = order[j];
            order[j] = swap;
        end
        if (kind >= 90) begin
            a = $urandom_range(0, 3);
            b = (a + $urandom_range(1, 3)) % 4;
            order[b] = order[a];
        end
        return make_trial(order[0], order[1], order[2], order[3],
                          crossover_random(), crossover_random());
    endfunction

    // Offers one request and predicts its result once it is taken.
    // Called and left at a falling edge; tvalid stays high when no gap follows.
    task automatic send_request(input request_t r);
        int       gap;
        outcome_t predicted;
        gap = sender_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {r.load_y, r.load_x, r.rand_y, r.rand_x,
                     r.minus_slot, r.plus_slot, r.base_slot, r.slot};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_to_population(r);
        pending_outcomes = {pending_outcomes, predicted};
        @(negedge aclk);
    endtask

    // Stops offering and waits until every result is back and the block is quiet.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [det_pkg::CFG_IDX_W-1:0] idx,
                             input logic [det_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        case (idx)
            det_pkg::CFG_RATE:    rate_q  = longint'(val[det_pkg::RATE_W-1:0]);
            det_pkg::CFG_SCALE:   scale_q = longint'(val[det_pkg::SCALE_W-1:0]);
            det_pkg::CFG_LOWER_X: lo_x    = longint'($signed(val[det_pkg::COORD_W-1:0]));
            det_pkg::CFG_UPPER_X: hi_x    = longint'($signed(val[det_pkg::COORD_W-1:0]));
            det_pkg::CFG_LOWER_Y: lo_y    = longint'($signed(val[det_pkg::COORD_W-1:0]));
            det_pkg::CFG_UPPER_Y: hi_y    = longint'($signed(val[det_pkg::COORD_W-1:0]));
            default: ;
        endcase
    endtask

    task automatic program_regs(input int rate, input int scale, input int lx, input int ux,
                                input int ly, input int uy);
        write_reg(det_pkg::CFG_RATE, 18'(rate));
        write_reg(det_pkg::CFG_SCALE, 18'(scale));
        write_reg(det_pkg::CFG_LOWER_X, 18'(lx));
        write_reg(det_pkg::CFG_UPPER_X, 18'(ux));
        write_reg(det_pkg::CFG_LOWER_Y, 18'(ly));
        write_reg(det_pkg::CFG_UPPER_Y, 18'(uy));
        settings_used++;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    // Repeated indices before any load: no store is read, best fields show reset values.
    task automatic test_rejects_after_reset();
        send_request(make_trial(4'd0, 4'd0, 4'd1, 4'd2, 16'h0000, 16'hFFFF));
        send_request(make_trial(4'd0, 4'd1, 4'd0, 4'd2, 16'hFFFF, 16'h0000));
        send_request(make_trial(4'd0, 4'd1, 4'd2, 4'd0, 16'h0000, 16'h0000));
        send_request(make_trial(4'd3, 4'd4, 4'd4, 4'd5, 16'hFFFF, 16'hFFFF));
        send_request(make_trial(4'd3, 4'd4, 4'd5, 4'd4, 16'h0000, 16'hFFFF));
        send_request(make_trial(4'd6, 4'd7, 4'd8, 4'd8, 16'hFFFF, 16'h0000));
        send_request(make_trial(4'd15, 4'd15, 4'd15, 4'd15, 16'h0000, 16'h0000));
        wait_until_idle();
    endtask

    // Fills every slot: saturating costs both ways, zero, and a tie with the reset minimum.
    task automatic test_population_load();
        send_request(make_load(4'd0, 16'h7FFF, 16'h7FFF));
        send_request(make_load(4'd1, 16'h8000, 16'h8000));
        send_request(make_load(4'd2, 16'h0000, 16'h0000));
        send_request(make_load(4'd3, 16'(det_pkg::BOUND_HI_RESET),
                               16'(det_pkg::BOUND_HI_RESET)));
        send_request(make_load(4'd4, 16'(det_pkg::BOUND_LO_RESET),
                               16'(det_pkg::BOUND_LO_RESET)));
        for (int s = 5; s < det_pkg::POP_SIZE_DEF; s++) begin
            send_request(make_load(4'(s), random_coord(), random_coord()));
        end
        wait_until_idle();
    endtask

    // Crossover randoms at zero, at the rate, one above it and at the top.
    task automatic test_crossover_choices();
        send_request(make_trial(4'd5, 4'd6, 4'd7, 4'd8, 16'h0000, 16'hFFFF));
        send_request(make_trial(4'd9, 4'd10, 4'd11, 4'd12,
                                16'(det_pkg::RATE_RESET), 16'(det_pkg::RATE_RESET + 1)));
        send_request(make_trial(4'd13, 4'd14, 4'd15, 4'd0, 16'hFFFF, 16'hFFFF));
        send_request(make_trial(4'd1, 4'd0, 4'd3, 4'd4,
                                16'(det_pkg::RATE_RESET + 1), 16'h0000));
        wait_until_idle();
    endtask

    // Rate and scale at both ends, full, crossed and collapsed bounds.
    task automatic test_register_extremes();
        program_regs(0, 131072, -32768, 32767, -32768, 32767);
        run_random(60);
        wait_until_idle();
        program_regs(65536, 0, det_pkg::BOUND_LO_RESET, det_pkg::BOUND_HI_RESET,
                     det_pkg::BOUND_LO_RESET, det_pkg::BOUND_HI_RESET);
        run_random(60);
        wait_until_idle();
        program_regs(65536, 131072, 4096, -4096, 32767, -32768);
        run_random(60);
        wait_until_idle();
        program_regs(32768, 65536, 0, 0, -32768, 32767);
        run_random(60);
        wait_until_idle();
    endtask

    // Random settings; one phase runs with both sides streaming without gaps.
    task automatic test_random_settings();
        int lx;
        int ux;
        int ly;
        int uy;
        int swap;
        for (int phase = 0; phase < 5; phase++) begin
            lx = -int'($urandom_range(0, 32768));
            ux = $urandom_range(0, 32767);
            ly = -int'($urandom_range(0, 32768));
            uy = $urandom_range(0, 32767);
            if ($urandom_range(0, 3) == 0) begin
                swap = lx;
                lx = ux;
                ux = swap;
            end
            program_regs($urandom_range(0, 65536), $urandom_range(0, 131072), lx, ux, ly, uy);
            sender_steady = (phase == 2);
            recv_steady = (phase == 2);
            run_random(200);
            wait_until_idle();
        end
        sender_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        program_regs(det_pkg::RATE_RESET, det_pkg::SCALE_RESET,
                     det_pkg::BOUND_LO_RESET, det_pkg::BOUND_HI_RESET,
                     det_pkg::BOUND_LO_RESET, det_pkg::BOUND_HI_RESET);
        hold_left = 150;
        sender_steady = 1'b1;
        run_random(30);
        sender_steady = 1'b0;
        wait_until_idle();
    endtask

    task automatic check_field(input string name, input logic [18:0] want,
                               input logic [18:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side ready: long hold first, then a random stall after each result.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: each taken result against the oldest prediction.
    always @(posedge aclk) begin : result_check
        outcome_t want;
        outcome_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.status     = det_pkg::status_t'(m_tuser);
            seen.point_cost = m_tdata[18:0];
            seen.point_x    = m_tdata[34:19];
            seen.point_y    = m_tdata[50:35];
            seen.best_slot  = m_tdata[54:51];
            seen.best_cost  = m_tdata[73:55];
            stall_left = recv_steady ? 0 : $urandom_range(0, 6);
            case (seen.status)
                det_pkg::ST_LOADED:   seen_loaded++;
                det_pkg::ST_REPLACED: seen_replaced++;
                det_pkg::ST_KEPT:     seen_kept++;
                default:              seen_rejected++;
            endcase
            if (pending_outcomes.size() == 0) begin
                $display("%0t ns: result with none expected, status %0d data %h",
                         $time, seen.status, m_tdata);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status", 19'(want.status), 19'(seen.status));
                check_field("point_cost", want.point_cost, seen.point_cost);
                check_field("point_x", 19'(want.point_x), 19'(seen.point_x));
                check_field("point_y", 19'(want.point_y), 19'(seen.point_y));
                check_field("best_slot", 19'(want.best_slot), 19'(seen.best_slot));
                check_field("best_cost", want.best_cost, seen.best_cost);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        sender_steady = 1'b0;
        recv_steady   = 1'b0;
        mismatches    = 0;
        settings_used = 1;
        rate_q  = det_pkg::RATE_RESET;
        scale_q = det_pkg::SCALE_RESET;
        lo_x = det_pkg::BOUND_LO_RESET;
        hi_x = det_pkg::BOUND_HI_RESET;
        lo_y = det_pkg::BOUND_LO_RESET;
        hi_y = det_pkg::BOUND_HI_RESET;
        lowest_cost = det_pkg::COST_MAX;
        lowest_slot = 0;
        for (int s = 0; s < det_pkg::POP_SIZE_DEF; s++) begin
            pop_x[s] = 0;
            pop_y[s] = 0;
            pop_cost[s] = 0;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_rejects_after_reset();
        test_population_load();
        test_crossover_choices();
        test_register_extremes();
        test_random_settings();
        test_output_backpressure();

        $display("Results: %0d loads, %0d replacements, %0d kept trials, %0d rejected.",
                 seen_loaded, seen_replaced, seen_kept, seen_rejected);
        $display("Ran %0d register settings, a gap-free phase and a long output stall.",
                 settings_used);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
